[rtl/polyphonic_wavetable_voice_bank_core_defines.svh]
// Assertion macros for the voice bank core.
// Used by the top level only; compiled out when SYNTH is defined.
`ifndef POLYPHONIC_WAVETABLE_VOICE_BANK_CORE_DEFINES_SVH
`define POLYPHONIC_WAVETABLE_VOICE_BANK_CORE_DEFINES_SVH

`ifndef SYNTH
// Generic check on clk_i, held off while rst_ni is low.
`define PWVB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pwvb check failed");
// Same-cycle implication.
`define PWVB_ASSERT_IMP(lbl, ante, cons) `PWVB_ASSERT(lbl, (ante) |-> (cons))
// Next-cycle implication.
`define PWVB_ASSERT_NXT(lbl, ante, cons) `PWVB_ASSERT(lbl, (ante) |=> (cons))
`else
`define PWVB_ASSERT(lbl, prop)
`define PWVB_ASSERT_IMP(lbl, ante, cons)
`define PWVB_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/pwvb_pkg.sv]
// Shared constants, types and control struct for the voice bank.
// No dependencies.
package pwvb_pkg;

  localparam int unsigned VOICE_COUNT = 8;
  localparam int unsigned TABLE_DEPTH = 1024;

  localparam int unsigned TABLE_AW = $clog2(TABLE_DEPTH);
  localparam int unsigned TDEPTH_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned VOICE_IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 7;
  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned TADDR_W  = 10;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned MASK_W   = 8;

  localparam int unsigned ACC_W  = SAMPLE_W + $clog2(VOICE_COUNT);
  localparam int unsigned PROD_W = ACC_W + GAIN_W + 1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'h8000;

  typedef enum logic [CMD_W-1:0] {
    CMD_NOTE_ON     = 2'd0,
    CMD_NOTE_OFF    = 2'd1,
    CMD_SAMPLE_TICK = 2'd2,
    CMD_TABLE_WRITE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MUL,
    ST_OUT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic                accept;     // input beat taken this cycle
    logic                clear_acc;  // tick beat: zero the mix accumulator
    logic                scan_en;    // read table for voice_idx, advance its phase
    logic [VOICE_IW-1:0] voice_idx;
    logic                mul_en;     // apply gain to the finished sum
    logic                load_out;   // load the output register
  } ctl_t;

endpackage

[rtl/pwvb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pwvb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pwvb_ctrl.sv]
// Sequencer for the voice bank: input handshake, voice scan, gain and output load.
// Depends on pwvb_pkg.
module pwvb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          cmd_i,
  input  logic                out_free_i,
  output logic                in_ready_o,
  output pwvb_pkg::ctl_t      ctl_o
);
  import pwvb_pkg::*;

  state_e              state_q, state_d;
  logic [VOICE_IW-1:0] cnt_q, cnt_d;
  logic                beat;
  logic                is_tick;
  logic                last_voice;

  assign beat       = in_valid_i && (state_q == ST_IDLE);
  assign is_tick    = (cmd_e'(cmd_i) == CMD_SAMPLE_TICK);
  assign last_voice = (cnt_q == VOICE_IW'(VOICE_COUNT - 1));

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (beat && is_tick) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_voice) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: state_d = ST_MUL;
      ST_MUL:   state_d = ST_OUT;
      ST_OUT: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o      = 1'b0;
    ctl_o           = '0;
    ctl_o.voice_idx = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        ctl_o.accept    = beat;
        ctl_o.clear_acc = beat && is_tick;
      end
      ST_SCAN:  ctl_o.scan_en  = 1'b1;
      ST_DRAIN: ;
      ST_MUL:   ctl_o.mul_en   = 1'b1;
      ST_OUT:   ctl_o.load_out = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[rtl/pwvb_dpath.sv]
// Voice bank datapath: voice registers, wave table, mix accumulator, gain, output.
// Depends on pwvb_pkg and pwvb_ram.
module pwvb_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pwvb_pkg::ctl_t               ctl_i,
  input  logic [1:0]                   cmd_i,
  input  logic [6:0]                   note_key_i,
  input  logic [31:0]                  phase_step_i,
  input  logic [9:0]                   table_addr_i,
  input  logic signed [15:0]           table_value_i,
  input  logic                         cfg_we_i,
  input  logic [15:0]                  cfg_wdata_i,
  input  logic                         out_ready_i,
  output logic                         out_free_o,
  output logic                         out_valid_o,
  output logic signed [15:0]           sample_o,
  output logic [7:0]                   active_mask_o
);
  import pwvb_pkg::*;

  // voice state
  logic [VOICE_COUNT-1:0] act_q, act_d;
  logic [KEY_W-1:0]       note_q  [VOICE_COUNT];
  logic [KEY_W-1:0]       note_d  [VOICE_COUNT];
  logic [PHASE_W-1:0]     step_q  [VOICE_COUNT];
  logic [PHASE_W-1:0]     step_d  [VOICE_COUNT];
  logic [PHASE_W-1:0]     phase_q [VOICE_COUNT];
  logic [PHASE_W-1:0]     phase_d [VOICE_COUNT];

  logic                free_hit, off_hit;
  logic [VOICE_IW-1:0] free_sel, off_sel;

  // table and mix
  logic                         tbl_we;
  logic [PHASE_W+TDEPTH_W-1:0]  idx_prod;
  logic [TABLE_AW-1:0]          tbl_raddr;
  logic [SAMPLE_W-1:0]          tbl_rdata;
  logic                         rd_vld_q;
  logic signed [ACC_W-1:0]      acc_q;
  logic [GAIN_W-1:0]            gain_q;
  logic signed [PROD_W-1:0]     prod_q;
  logic signed [PROD_W-1:0]     scaled;
  logic signed [SAMPLE_W-1:0]   sat;
  logic [MASK_W-1:0]            mask;

  logic                         out_valid_q;
  logic signed [SAMPLE_W-1:0]   out_sample_q;
  logic [MASK_W-1:0]            out_mask_q;

  // lowest free voice and lowest matching active voice
  always_comb begin
    free_hit = 1'b0;
    free_sel = '0;
    off_hit  = 1'b0;
    off_sel  = '0;
    for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
      if (!act_q[v]) begin
        free_hit = 1'b1;
        free_sel = VOICE_IW'(v);
      end
      if (act_q[v] && (note_q[v] == note_key_i)) begin
        off_hit = 1'b1;
        off_sel = VOICE_IW'(v);
      end
    end
  end

  always_comb begin
    act_d   = act_q;
    note_d  = note_q;
    step_d  = step_q;
    phase_d = phase_q;
    tbl_we  = 1'b0;
    if (ctl_i.accept) begin
      unique case (cmd_e'(cmd_i))
        CMD_NOTE_ON: begin
          if (free_hit) begin
            act_d[free_sel]   = 1'b1;
            note_d[free_sel]  = note_key_i;
            step_d[free_sel]  = phase_step_i;
            phase_d[free_sel] = '0;
          end
        end
        CMD_NOTE_OFF: begin
          if (off_hit) begin
            act_d[off_sel]   = 1'b0;
            note_d[off_sel]  = '0;
            step_d[off_sel]  = '0;
            phase_d[off_sel] = '0;
          end
        end
        CMD_TABLE_WRITE: tbl_we = (32'(table_addr_i) < 32'(TABLE_DEPTH));
        CMD_SAMPLE_TICK: ;
        default: ;
      endcase
    end
    // table read uses the old phase; advance it in the same cycle
    if (ctl_i.scan_en && act_q[ctl_i.voice_idx]) begin
      phase_d[ctl_i.voice_idx] = phase_q[ctl_i.voice_idx] + step_q[ctl_i.voice_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        note_q[v]  <= '0;
        step_q[v]  <= '0;
        phase_q[v] <= '0;
      end
    end else begin
      act_q   <= act_d;
      note_q  <= note_d;
      step_q  <= step_d;
      phase_q <= phase_d;
    end
  end

  // index = floor(phase * depth / 2^32)
  assign idx_prod  = (PHASE_W+TDEPTH_W)'(phase_q[ctl_i.voice_idx])
                   * (PHASE_W+TDEPTH_W)'(TABLE_DEPTH);
  assign tbl_raddr = idx_prod[PHASE_W +: TABLE_AW];

  pwvb_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_wave_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (TABLE_AW'(table_addr_i)),
    .wdata_i (table_value_i),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      gain_q   <= GAIN_RESET;
    end else begin
      rd_vld_q <= ctl_i.scan_en && act_q[ctl_i.voice_idx];
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.clear_acc) begin
      acc_q <= '0;
    end else if (rd_vld_q) begin
      acc_q <= acc_q + ACC_W'(signed'(tbl_rdata));
    end
    if (ctl_i.mul_en) begin
      prod_q <= PROD_W'(acc_q) * signed'({1'b0, gain_q});
    end
  end

  // arithmetic shift floors, then clamp
  assign scaled = prod_q >>> 15;
  always_comb begin
    if (scaled > PROD_W'(32767)) begin
      sat = 16'sh7fff;
    end else if (scaled < -PROD_W'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = SAMPLE_W'(scaled);
    end
  end

  always_comb begin
    mask = '0;
    for (int v = 0; v < VOICE_COUNT; v++) begin
      if (v < MASK_W) begin
        mask[v] = act_q[v];
      end
    end
  end

  assign out_free_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_out) begin
      out_sample_q <= sat;
      out_mask_q   <= mask;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_o      = out_sample_q;
  assign active_mask_o = out_mask_q;

endmodule

[rtl/polyphonic_wavetable_voice_bank_core.sv]
// Top level of the polyphonic wavetable voice bank.
// Depends on pwvb_pkg, pwvb_ctrl, pwvb_dpath (with pwvb_ram) and the defines header.
//
//  channel | handshake                | payload
//  --------+--------------------------+----------------------------------------------
//  in      | in_valid_i / in_ready_o  | cmd_i note_key_i phase_step_i table_addr_i
//          |                          | table_value_i
//  out     | out_valid_o / out_ready_i| sample_o active_mask_o
//  cfg     | cfg_we_i                 | cfg_wdata_i (output gain, unsigned Q1.15)
//
// note_on, note_off and table_write are applied when their beat is taken; the block stays idle.
// sample_tick reads the wave table once per voice on the single RAM read port, then passes
// through a drain state, a gain multiply and an output load.
// The result sits in an output register; the next beat is taken while it waits, and a
// tick stalls only in its output load state if the previous result is still unread.
// Reset: voices off, gain 1.0, output empty; the wave table is not cleared.
`include "polyphonic_wavetable_voice_bank_core_defines.svh"

module polyphonic_wavetable_voice_bank_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [6:0]         note_key_i,
  input  logic [31:0]        phase_step_i,
  input  logic [9:0]         table_addr_i,
  input  logic signed [15:0] table_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_o,
  output logic [7:0]         active_mask_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i
);
  import pwvb_pkg::*;

  ctl_t ctl;
  logic out_free;
  logic tick_beat;

  // sequencer: owns the handshake and the voice counter
  pwvb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .out_free_i (out_free),
    .in_ready_o (in_ready_o),
    .ctl_o      (ctl)
  );

  // voices, table, mixer and output register
  pwvb_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .cmd_i         (cmd_i),
    .note_key_i    (note_key_i),
    .phase_step_i  (phase_step_i),
    .table_addr_i  (table_addr_i),
    .table_value_i (table_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_ready_i   (out_ready_i),
    .out_free_o    (out_free),
    .out_valid_o   (out_valid_o),
    .sample_o      (sample_o),
    .active_mask_o (active_mask_o)
  );

  assign tick_beat = in_valid_i && in_ready_o && (cmd_e'(cmd_i) == CMD_SAMPLE_TICK);

  // a tick beat puts the block busy for the scan
  `PWVB_ASSERT_NXT(a_tick_busy, tick_beat, !in_ready_o)
  // no beat is taken while voices are being scanned
  `PWVB_ASSERT_IMP(a_scan_no_beat, ctl.scan_en, !in_ready_o)
  // a new result only appears after the sequencer loads it
  `PWVB_ASSERT_IMP(a_out_from_load, $rose(out_valid_o), $past(ctl.load_out))

endmodule
